FILE: rtl/mah_pkg.sv
// mah_pkg: shared constants, types and helpers of the moving average alarm
// used by mah_alarm and moving_average_hysteresis_alarm; no dependencies

package mah_pkg;

  // averaging window length and used sample width
  localparam int unsigned WINDOW      = 16;
  localparam int unsigned SAMPLE_BITS = 12;

  // fixed widths of the port fields
  localparam int unsigned IN_W  = 12;
  localparam int unsigned AVG_W = 12;
  localparam int unsigned THR_W = 12;

  // derived widths
  localparam int unsigned POS_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int unsigned SUM_W = SAMPLE_BITS + $clog2(WINDOW);
  localparam int unsigned CMP_W = (SUM_W > THR_W) ? SUM_W : THR_W;

  // threshold handling
  localparam logic [THR_W-1:0] HYST_MARGIN     = THR_W'(20);
  localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(500);

  // largest value the running sum can reach
  localparam logic [SUM_W-1:0] SUM_MAX = SUM_W'(WINDOW * ((2 ** SAMPLE_BITS) - 1));

  // alarm decision for one item
  typedef struct packed {
    logic active;
    logic changed;
  } alarm_t;

  // keep only the used low bits of a raw reading
  function automatic logic [SAMPLE_BITS-1:0] to_sample(input logic [IN_W-1:0] raw);
    logic [31:0] wide;
    wide = 32'(raw);
    return wide[SAMPLE_BITS-1:0];
  endfunction

endpackage

FILE: rtl/mah_alarm.sv
// mah_alarm: hysteresis comparator deciding the next alarm flag
// depends on mah_pkg

module mah_alarm (
  input  logic [mah_pkg::CMP_W-1:0] avg_i,
  input  logic [mah_pkg::THR_W-1:0] threshold_i,
  input  logic                      flag_i,
  output mah_pkg::alarm_t           alarm_o
);

  logic [mah_pkg::THR_W-1:0] margin;
  logic [mah_pkg::THR_W-1:0] release_lvl;
  logic                      set_hit;
  logic                      clr_hit;

  // margin drops to zero when it would exceed the threshold
  assign margin      = (mah_pkg::HYST_MARGIN > threshold_i) ? '0 : mah_pkg::HYST_MARGIN;
  assign release_lvl = threshold_i - margin;
  assign set_hit     = (avg_i >= mah_pkg::CMP_W'(threshold_i));
  assign clr_hit     = (avg_i <  mah_pkg::CMP_W'(release_lvl));

  always_comb begin
    alarm_o.active = flag_i;
    priority if (!flag_i && set_hit) begin
      alarm_o.active = 1'b1;
    end else if (flag_i && clr_hit) begin
      alarm_o.active = 1'b0;
    end else begin
      alarm_o.active = flag_i;
    end
    alarm_o.changed = (alarm_o.active != flag_i);
  end

endmodule

FILE: rtl/moving_average_hysteresis_alarm.sv
// moving_average_hysteresis_alarm: top level, sample ring, running sum and result register
// depends on mah_pkg and mah_alarm

// usage
// - input channel: in_valid_i / in_stall_o carry one converter sample per item
//   on sample_i; an item is taken at a clock edge with valid high and stall low
// - output channel: out_valid_o / out_stall_i carry one result per item:
//   average_level_o, alarm_active_o and alarm_changed_o
// - cfg_we_i writes cfg_wdata_i into the alarm threshold at the clock edge;
//   write it only while no item is in flight
// - two register stages: an accepted item sits in the input register, then the
//   ring update, sum, divide by the window and hysteresis compare run
//   combinationally into the result register; out_valid_o rises when the item
//   moves from the input register into the result register, a move that waits
//   while the receiver stalls a pending result; throughput one item per cycle while out_stall_i is low
// - the running sum loop (old ring entry out, new sample in) sets the rate:
//   it closes combinationally from sum_q through sum_d back into sum_q
// - when the receiver stalls, the result register holds; the input register
//   still takes one more item, after which in_stall_o rises
// - reset (rst_ni low, asynchronous) empties both stages, zeroes the ring, the
//   sum, the write position and the alarm flag, and sets the threshold to 500

module moving_average_hysteresis_alarm (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  // configuration
  input  logic                      cfg_we_i,
  input  logic [mah_pkg::THR_W-1:0] cfg_wdata_i,
  // input channel
  input  logic                      in_valid_i,
  output logic                      in_stall_o,
  input  logic [mah_pkg::IN_W-1:0]  sample_i,
  // output channel
  output logic                      out_valid_o,
  input  logic                      out_stall_i,
  output logic [mah_pkg::AVG_W-1:0] average_level_o,
  output logic                      alarm_active_o,
  output logic                      alarm_changed_o
);

  // threshold register
  logic [mah_pkg::THR_W-1:0] thr_q;

  // input register
  logic                            in_valid_q;
  logic [mah_pkg::SAMPLE_BITS-1:0] sample_q;

  // averaging state
  logic [mah_pkg::SAMPLE_BITS-1:0] ring_q [mah_pkg::WINDOW];
  logic [mah_pkg::SUM_W-1:0]       sum_q, sum_d;
  logic [mah_pkg::POS_W-1:0]       pos_q, pos_d;
  logic                            alarm_q;

  // result register
  logic                      out_valid_q;
  logic [mah_pkg::AVG_W-1:0] avg_q;
  logic                      act_q;
  logic                      chg_q;

  logic                      out_free;
  logic                      advance;
  logic                      in_take;
  logic [mah_pkg::CMP_W-1:0] avg_d;
  mah_pkg::alarm_t           alarm_d;

  // handshake: result register frees up when empty or being taken
  assign out_free   = !out_valid_q || !out_stall_i;
  assign advance    = in_valid_q && out_free;
  assign in_stall_o = in_valid_q && !out_free;
  assign in_take    = in_valid_i && !in_stall_o;

  // sum update: drop the oldest sample, add the new one
  assign sum_d = sum_q - mah_pkg::SUM_W'(ring_q[pos_q]) + mah_pkg::SUM_W'(sample_q);
  assign pos_d = (pos_q == mah_pkg::POS_W'(mah_pkg::WINDOW - 1)) ? '0 : pos_q + 1'b1;
  assign avg_d = mah_pkg::CMP_W'(sum_d) / mah_pkg::CMP_W'(mah_pkg::WINDOW);

  mah_alarm u_alarm (
    .avg_i       (avg_d),
    .threshold_i (thr_q),
    .flag_i      (alarm_q),
    .alarm_o     (alarm_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= mah_pkg::THRESHOLD_RESET;
    end else if (cfg_we_i) begin
      thr_q <= cfg_wdata_i;
    end
  end

  // input stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_take) begin
      in_valid_q <= 1'b1;
    end else if (advance) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sample_q <= mah_pkg::to_sample(sample_i);
    end
  end

  // ring, sum, write position and alarm flag move together with each item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < int'(mah_pkg::WINDOW); i++) begin
        ring_q[i] <= '0;
      end
      sum_q   <= '0;
      pos_q   <= '0;
      alarm_q <= 1'b0;
    end else if (advance) begin
      ring_q[pos_q] <= sample_q;
      sum_q         <= sum_d;
      pos_q         <= pos_d;
      alarm_q       <= alarm_d.active;
    end
  end

  // result stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      avg_q <= avg_d[mah_pkg::AVG_W-1:0];
      act_q <= alarm_d.active;
      chg_q <= alarm_d.changed;
    end
  end

  assign out_valid_o     = out_valid_q;
  assign average_level_o = avg_q;
  assign alarm_active_o  = act_q;
  assign alarm_changed_o = chg_q;

`ifndef SYNTHESIS
  // the pending result always shows the current alarm flag
  a_flag_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> (act_q == alarm_q))
    else $error("result alarm flag differs from alarm state");

  // running sum stays within the window's full scale
  a_sum_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    sum_q <= mah_pkg::SUM_MAX)
    else $error("running sum out of range");

  // an item leaving the input register lands in the result register
  a_advance_lands : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> out_valid_q)
    else $error("processed item lost");

  // a change pulse always comes with a flag that differs from the one before
  a_change_flip : assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance |=> (chg_q == (alarm_q != $past(alarm_q))))
    else $error("change pulse does not match flag transition");
`endif

endmodule
